@@ hw/rtl/jacobi_stencil_sweep_assert.svh @@
// assertion macros for the jacobi stencil sweep block
`ifndef JACOBI_STENCIL_SWEEP_ASSERT_SVH
`define JACOBI_STENCIL_SWEEP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define JSS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define JSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define JSS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define JSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ hw/rtl/jss_pkg.sv @@
// shared constants and types of the jacobi stencil sweep block
`default_nettype none
package jss_pkg;

   // default sizes
   localparam int MAX_COLS_DEF    = 256;
   localparam int MAX_ROWS_DEF    = 1024;
   localparam int VALUE_WIDTH_DEF = 32;

   // smallest grid side, boundary included
   localparam int MIN_GRID = 3;

   // register file
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int GRID_ROWS_W = 11;
   localparam int GRID_COLS_W = 9;
   localparam int EPSILON_W   = 32;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type REG_GRID_ROWS = 2'd0;
   localparam csr_index_type REG_GRID_COLS = 2'd1;
   localparam csr_index_type REG_EPSILON   = 2'd2;

   localparam logic [GRID_ROWS_W-1:0] GRID_ROWS_RST = 11'd200;
   localparam logic [GRID_COLS_W-1:0] GRID_COLS_RST = 9'd200;
   localparam logic [EPSILON_W-1:0]   EPSILON_RST   = 32'd4194;

   // flags that travel with each request down the pipeline
   typedef struct packed {
      logic emit;       // request completes an interior cell
      logic last;       // that cell is the final interior cell
      logic sweep_end;  // request is the final cell of the grid
   } tag_type;

endpackage
`default_nettype wire

@@ hw/rtl/jss_ram.sv @@
// generic single-write, single-read ram with registered read
`default_nettype none
module jss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ hw/rtl/jss_window_cell.sv @@
// one column of the 3x3 stencil window, shifted to its neighbor per request
`default_nettype none
module jss_window_cell #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   shift_en,
   input  wire logic [VALUE_WIDTH-1:0] top_in,
   input  wire logic [VALUE_WIDTH-1:0] mid_in,
   input  wire logic [VALUE_WIDTH-1:0] bot_in,
   output logic      [VALUE_WIDTH-1:0] top_out,
   output logic      [VALUE_WIDTH-1:0] mid_out,
   output logic      [VALUE_WIDTH-1:0] bot_out
);

   logic [VALUE_WIDTH-1:0] top_ff;
   logic [VALUE_WIDTH-1:0] mid_ff;
   logic [VALUE_WIDTH-1:0] bot_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         top_ff <= top_in;
         mid_ff <= mid_in;
         bot_ff <= bot_in;
      end
   end

   assign top_out = top_ff;
   assign mid_out = mid_ff;
   assign bot_out = bot_ff;

endmodule
`default_nettype wire

@@ hw/rtl/jss_point_update.sv @@
// two-stage point update: quarter of neighbor sum, then absolute change
`default_nettype none
module jss_point_update import jss_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int ROW_W       = 10,
   parameter int COL_W       = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   adv,
   input  wire logic                   in_valid,
   input  wire tag_type                in_tag,
   input  wire logic [ROW_W-1:0]       in_row,
   input  wire logic [COL_W-1:0]       in_col,
   input  wire logic [VALUE_WIDTH-1:0] up,
   input  wire logic [VALUE_WIDTH-1:0] down,
   input  wire logic [VALUE_WIDTH-1:0] left,
   input  wire logic [VALUE_WIDTH-1:0] right,
   input  wire logic [VALUE_WIDTH-1:0] centre,
   output logic                        out_valid,
   output tag_type                     out_tag,
   output logic      [ROW_W-1:0]       out_row,
   output logic      [COL_W-1:0]       out_col,
   output logic      [VALUE_WIDTH-1:0] new_value,
   output logic      [VALUE_WIDTH-1:0] cell_change
);

   localparam int SUM_W = VALUE_WIDTH + 2;

   logic [SUM_W-1:0]       sum;
   logic                   a_valid_ff;
   tag_type                a_tag_ff;
   logic [ROW_W-1:0]       a_row_ff;
   logic [COL_W-1:0]       a_col_ff;
   logic [VALUE_WIDTH-1:0] a_nv_ff;
   logic [VALUE_WIDTH-1:0] a_centre_ff;
   logic [VALUE_WIDTH-1:0] change;
   logic                   b_valid_ff;
   tag_type                b_tag_ff;
   logic [ROW_W-1:0]       b_row_ff;
   logic [COL_W-1:0]       b_col_ff;
   logic [VALUE_WIDTH-1:0] b_nv_ff;
   logic [VALUE_WIDTH-1:0] b_change_ff;

   // full-width sum, so the quarter always fits
   assign sum = SUM_W'(up) + SUM_W'(down) + SUM_W'(left) + SUM_W'(right);

   assign change = (a_nv_ff >= a_centre_ff) ? (a_nv_ff - a_centre_ff)
                                            : (a_centre_ff - a_nv_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_tag_ff    <= in_tag;
         a_row_ff    <= in_row;
         a_col_ff    <= in_col;
         a_nv_ff     <= sum[SUM_W-1:2];
         a_centre_ff <= centre;
         b_tag_ff    <= a_tag_ff;
         b_row_ff    <= a_row_ff;
         b_col_ff    <= a_col_ff;
         b_nv_ff     <= a_nv_ff;
         b_change_ff <= change;
      end
   end

   assign out_valid   = b_valid_ff;
   assign out_tag     = b_tag_ff;
   assign out_row     = b_row_ff;
   assign out_col     = b_col_ff;
   assign new_value   = b_nv_ff;
   assign cell_change = b_change_ff;

endmodule
`default_nettype wire

@@ hw/rtl/jacobi_stencil_sweep.sv @@
// top level of the streaming five-point jacobi stencil sweep
// The block takes one grid cell per clock cycle in row-major order and, once
// the third row and third column are reached, returns the updated value of
// the interior cell up and to the left of the one just taken, with its row,
// column, absolute change and the running maximum change of the sweep. The
// final interior cell is flagged on rsp_tlast, with the converged flag on
// rsp_tuser. Throughput is one request per cycle; a request passes through
// the stage 1 register, the stage 2 window, the two update stages and the
// output register. The two line buffers are rams with one read and one write
// port each, read at the column of the arriving cell and written there once
// that cell has reached stage 1. A stall on the result side holds the whole
// pipeline, so req_tready drops only while a result waits and rsp_tready is
// low. Line buffer contents are undefined after reset and need no clearing.
`default_nettype none
`include "jacobi_stencil_sweep_assert.svh"
module jacobi_stencil_sweep import jss_pkg::*; #(
   parameter int MAX_COLS    = MAX_COLS_DEF,
   parameter int MAX_ROWS    = MAX_ROWS_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   localparam int ROW_W       = $clog2(MAX_ROWS),
   localparam int COL_W       = $clog2(MAX_COLS),
   localparam int REQ_TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8,
   localparam int RSP_BITS    = 3 * VALUE_WIDTH + ROW_W + COL_W,
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request side
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // cell_value
   // result side
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,   // new_value, out_row, out_col,
                                                    // cell_change, max_change
   output logic                        rsp_tlast,
   output logic                        rsp_tuser,   // converged
   // register writes
   input  wire logic                   csr_wr_en,
   input  wire csr_index_type          csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // widths for size arithmetic: room for both the register and the maximum
   localparam int ROWS_W = (GRID_ROWS_W > ROW_W + 1) ? GRID_ROWS_W : ROW_W + 1;
   localparam int COLS_W = (GRID_COLS_W > COL_W + 1) ? GRID_COLS_W : COL_W + 1;
   localparam int CMP_W  = (VALUE_WIDTH > EPSILON_W) ? VALUE_WIDTH : EPSILON_W;

   // ---------------------------------------------------------------- registers
   logic [GRID_ROWS_W-1:0] grid_rows_ff;
   logic [GRID_COLS_W-1:0] grid_cols_ff;
   logic [EPSILON_W-1:0]   epsilon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= GRID_ROWS_RST;
         grid_cols_ff <= GRID_COLS_RST;
         epsilon_ff   <= EPSILON_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_GRID_ROWS: grid_rows_ff <= csr_wdata[GRID_ROWS_W-1:0];
            REG_GRID_COLS: grid_cols_ff <= csr_wdata[GRID_COLS_W-1:0];
            REG_EPSILON:   epsilon_ff   <= csr_wdata[EPSILON_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // grid sizes saturated into their legal ranges
   logic [ROWS_W-1:0] rows_cfg;
   logic [ROWS_W-1:0] rows_eff;
   logic [ROWS_W-1:0] rows_last;
   logic [COLS_W-1:0] cols_cfg;
   logic [COLS_W-1:0] cols_eff;
   logic [COLS_W-1:0] cols_last;

   assign rows_cfg = ROWS_W'(grid_rows_ff);
   assign cols_cfg = COLS_W'(grid_cols_ff);

   always_comb begin
      if (rows_cfg < ROWS_W'(MIN_GRID)) begin
         rows_eff = ROWS_W'(MIN_GRID);
      end else if (rows_cfg > ROWS_W'(MAX_ROWS)) begin
         rows_eff = ROWS_W'(MAX_ROWS);
      end else begin
         rows_eff = rows_cfg;
      end
      if (cols_cfg < COLS_W'(MIN_GRID)) begin
         cols_eff = COLS_W'(MIN_GRID);
      end else if (cols_cfg > COLS_W'(MAX_COLS)) begin
         cols_eff = COLS_W'(MAX_COLS);
      end else begin
         cols_eff = cols_cfg;
      end
   end

   assign rows_last = rows_eff - ROWS_W'(1);
   assign cols_last = cols_eff - COLS_W'(1);

   // ------------------------------------------------------------ flow control
   // one stall signal for the whole pipeline: move whenever the output
   // register is empty or is being drained
   logic adv;
   logic req_accept;
   logic rsp_valid_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign req_accept = req_tvalid && adv;

   // ---------------------------------------------------- position of the cell
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic             row_at_end;
   logic             col_at_end;
   tag_type          tag0;

   assign row_at_end = ROWS_W'(row_ff) >= rows_last;
   assign col_at_end = COLS_W'(col_ff) >= cols_last;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (req_accept) begin
         if (col_at_end) begin
            col_in = '0;
            row_in = row_at_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // the arriving cell (r,c) completes interior cell (r-1,c-1)
   assign tag0.emit      = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
   assign tag0.last      = (ROWS_W'(row_ff) == rows_last) && (COLS_W'(col_ff) == cols_last);
   assign tag0.sweep_end = row_at_end && col_at_end;

   // ------------------------------------------------ stage 1: line buffer read
   logic                   s1_valid_ff;
   logic [VALUE_WIDTH-1:0] s1_value_ff;
   logic [COL_W-1:0]       s1_addr_ff;
   logic [ROW_W-1:0]       s1_row_ff;
   logic [COL_W-1:0]       s1_col_ff;
   tag_type                s1_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_value_ff <= req_tdata[VALUE_WIDTH-1:0];
         s1_addr_ff  <= col_ff;
         s1_row_ff   <= row_ff - ROW_W'(1);
         s1_col_ff   <= col_ff - COL_W'(1);
         s1_tag_ff   <= tag0;
      end
   end

   // line a holds the row above the arriving one, line b the row above that;
   // both are read at the arriving column and rewritten there once that cell reaches stage 1
   logic                   line_wr;
   logic [VALUE_WIDTH-1:0] line_a_q;
   logic [VALUE_WIDTH-1:0] line_b_q;

   assign line_wr = adv && s1_valid_ff;

   jss_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (MAX_COLS)
   ) u_line_a (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_value_ff),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (line_a_q)
   );

   jss_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (MAX_COLS)
   ) u_line_b (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (s1_addr_ff),
      .wr_data (line_a_q),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (line_b_q)
   );

   // ------------------------------------------------- stage 2: stencil window
   // three window columns shift right by one per request: cell 0 holds the
   // arriving column, cell 1 the centre column, cell 2 the left column
   logic                   s2_valid_ff;
   logic [ROW_W-1:0]       s2_row_ff;
   logic [COL_W-1:0]       s2_col_ff;
   tag_type                s2_tag_ff;
   logic [VALUE_WIDTH-1:0] w0_top;
   logic [VALUE_WIDTH-1:0] w0_mid;
   logic [VALUE_WIDTH-1:0] w0_bot;
   logic [VALUE_WIDTH-1:0] w1_top;
   logic [VALUE_WIDTH-1:0] w1_mid;
   logic [VALUE_WIDTH-1:0] w1_bot;
   logic [VALUE_WIDTH-1:0] w2_mid;

   jss_window_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_cell_0 (
      .clock    (clock),
      .shift_en (line_wr),
      .top_in   (line_b_q),
      .mid_in   (line_a_q),
      .bot_in   (s1_value_ff),
      .top_out  (w0_top),
      .mid_out  (w0_mid),
      .bot_out  (w0_bot)
   );

   jss_window_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_cell_1 (
      .clock    (clock),
      .shift_en (line_wr),
      .top_in   (w0_top),
      .mid_in   (w0_mid),
      .bot_in   (w0_bot),
      .top_out  (w1_top),
      .mid_out  (w1_mid),
      .bot_out  (w1_bot)
   );

   jss_window_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_cell_2 (
      .clock    (clock),
      .shift_en (line_wr),
      .top_in   (w1_top),
      .mid_in   (w1_mid),
      .bot_in   (w1_bot),
      .top_out  (),
      .mid_out  (w2_mid),
      .bot_out  ()
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_row_ff <= s1_row_ff;
         s2_col_ff <= s1_col_ff;
         s2_tag_ff <= s1_tag_ff;
      end
   end

   // ---------------------------------------------- stages 3 and 4: arithmetic
   logic                   s4_valid;
   tag_type                s4_tag;
   logic [ROW_W-1:0]       s4_row;
   logic [COL_W-1:0]       s4_col;
   logic [VALUE_WIDTH-1:0] s4_value;
   logic [VALUE_WIDTH-1:0] s4_change;

   jss_point_update #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .ROW_W       (ROW_W),
      .COL_W       (COL_W)
   ) u_update (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (s2_valid_ff),
      .in_tag      (s2_tag_ff),
      .in_row      (s2_row_ff),
      .in_col      (s2_col_ff),
      .up          (w1_top),
      .down        (w1_bot),
      .left        (w2_mid),
      .right       (w0_mid),
      .centre      (w1_mid),
      .out_valid   (s4_valid),
      .out_tag     (s4_tag),
      .out_row     (s4_row),
      .out_col     (s4_col),
      .new_value   (s4_value),
      .cell_change (s4_change)
   );

   // ------------------------------------------ running maximum and result reg
   logic [VALUE_WIDTH-1:0] max_ff;
   logic [VALUE_WIDTH-1:0] max_in;
   logic [VALUE_WIDTH-1:0] max_cand;
   logic                   rsp_valid_in;
   logic                   converged_in;
   logic                   rsp_load;
   logic [VALUE_WIDTH-1:0] rsp_nv_ff;
   logic [ROW_W-1:0]       rsp_row_ff;
   logic [COL_W-1:0]       rsp_col_ff;
   logic [VALUE_WIDTH-1:0] rsp_ch_ff;
   logic [VALUE_WIDTH-1:0] rsp_max_ff;
   logic                   rsp_last_ff;
   logic                   rsp_conv_ff;

   assign max_cand     = (s4_change > max_ff) ? s4_change : max_ff;
   assign converged_in = s4_tag.last && (CMP_W'(max_cand) <= CMP_W'(epsilon_ff));
   assign rsp_load     = adv && s4_valid && s4_tag.emit;

   always_comb begin
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = s4_valid && s4_tag.emit;
         if (s4_valid) begin
            // the last cell of the grid closes the sweep
            if (s4_tag.sweep_end) begin
               max_in = '0;
            end else if (s4_tag.emit) begin
               max_in = max_cand;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_nv_ff   <= s4_value;
         rsp_row_ff  <= s4_row;
         rsp_col_ff  <= s4_col;
         rsp_ch_ff   <= s4_change;
         rsp_max_ff  <= max_cand;
         rsp_last_ff <= s4_tag.last;
         rsp_conv_ff <= converged_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_max_ff, rsp_ch_ff, rsp_col_ff, rsp_row_ff, rsp_nv_ff});
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_conv_ff;

   // --------------------------------------------------------------- checks
   `JSS_ASSERT_IMPLY(a_conv_only_last, clock, reset, rsp_tvalid && !rsp_tlast,
                     !rsp_tuser, "converged set on a result that is not last")
   `JSS_ASSERT_IMPLY(a_max_covers_change, clock, reset, rsp_tvalid,
                     rsp_max_ff >= rsp_ch_ff, "running maximum below cell change")
   `JSS_ASSERT_NEXT(a_max_cleared, clock, reset, adv && s4_valid && s4_tag.sweep_end,
                    max_ff == '0, "running maximum not cleared at end of sweep")

endmodule
`default_nettype wire
